// ----- hw/rtl/sps_pkg.sv -----
// types, constants and helper functions for the shooter and pickup sequencer
`timescale 1ns / 1ps

package sps_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_BACK_OFF_TICKS     = 2'd0,
    CFG_SPIN_UP_TICKS      = 2'd1,
    CFG_MIN_SHOT_SPEED     = 2'd2,
    CFG_DEFAULT_SHOT_SPEED = 2'd3
  } cfg_idx_e;

  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 16;

  // sequencing constants, drive values in Q1.15
  localparam logic [15:0] RampStep    = 16'd66;     // 0.002 of full scale
  localparam logic [7:0]  HoldLimit   = 8'd200;
  localparam logic [15:0] BrakeTicks  = 16'd5;
  localparam logic [15:0] ReleaseTicks = 16'd75;
  localparam logic [15:0] BrakeDrive  = 16'hE000;   // -0.25
  localparam logic [15:0] HalfDrive   = 16'h4000;   // 0.5
  localparam logic [15:0] NegHalfDrive = 16'hC000;  // -0.5
  localparam logic [15:0] PhaseReset  = 16'd1000;

  // configuration reset values
  localparam logic [15:0] BackOffReset  = 16'd50;
  localparam logic [15:0] SpinUpReset   = 16'd100;
  localparam logic [14:0] MinSpeedReset = 15'd16384;
  localparam logic [14:0] DefSpeedReset = 15'd24576;

  typedef struct packed {
    logic               trigger_held;
    logic               reverse_held;
    logic               advance_held;
    logic               override_held;
    logic               camera_locked;
    logic signed [15:0] stick_y;
    logic signed [15:0] stick_z;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] shooter_drive;
    logic signed [15:0] pickup_drive;
  } drive_t;

  typedef struct packed {
    logic [15:0] back_off_ticks;
    logic [15:0] spin_up_ticks;
    logic [14:0] min_shot_speed;
    logic [14:0] default_shot_speed;
  } cfg_t;

  typedef struct packed {
    logic [15:0] phase_count;
    logic [7:0]  hold_count;
    logic        last_trigger;
    logic [15:0] pickup_hold;
  } state_t;

  // ramp magnitude n * 66, fits 16 bits for any 8 bit n
  function automatic logic [15:0] ramp_mag(logic [7:0] n);
    return 16'({8'd0, n} * RampStep);
  endfunction

endpackage

// ----- hw/rtl/sps_if.sv -----
// valid/ready channel interfaces for command and drive transactions
`timescale 1ns / 1ps

interface sps_cmd_if import sps_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sps_drive_if import sps_pkg::*; ();
  logic   valid;
  logic   ready;
  drive_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/sps_step.sv -----
// next-state and drive computation for one control tick
`timescale 1ns / 1ps

module sps_step import sps_pkg::*; (
  input  cmd_t   cmd_i,
  input  cfg_t   cfg_i,
  input  state_t st_i,
  output state_t st_o,
  output drive_t drv_o
);

  logic [7:0]         hold_inc;
  logic [15:0]        phase_inc;
  logic [15:0]        mag;
  logic [16:0]        feed_limit;
  logic signed [15:0] min_s;
  logic signed [15:0] speed;
  logic [15:0]        shoot;

  always_comb begin
    hold_inc   = (st_i.hold_count == 8'hFF) ? st_i.hold_count : st_i.hold_count + 8'd1;
    phase_inc  = (&st_i.phase_count) ? st_i.phase_count : st_i.phase_count + 16'd1;
    feed_limit = {1'b0, cfg_i.back_off_ticks} + {1'b0, cfg_i.spin_up_ticks};
    min_s      = $signed({1'b0, cfg_i.min_shot_speed});

    // shooter speed once spin-up starts
    if (cmd_i.override_held) begin
      speed = (cmd_i.stick_z < min_s) ? min_s : cmd_i.stick_z;
    end else if (cmd_i.camera_locked) begin
      speed = $signed({1'b0, cfg_i.default_shot_speed});
    end else begin
      speed = min_s;
    end

    st_o  = st_i;
    shoot = 16'd0;
    mag   = 16'd0;

    if (cmd_i.reverse_held || cmd_i.advance_held) begin
      st_o.hold_count = hold_inc;
      mag   = (hold_inc < HoldLimit) ? ramp_mag(hold_inc) : HalfDrive;
      shoot = cmd_i.reverse_held ? 16'd0 - mag : mag;
    end else begin
      st_o.hold_count = 8'd0;
      if (cmd_i.trigger_held != st_i.last_trigger) begin
        st_o.phase_count  = 16'd0;
        st_o.last_trigger = cmd_i.trigger_held;
        st_o.pickup_hold  = cmd_i.trigger_held ? NegHalfDrive : cmd_i.stick_y;
      end else if (cmd_i.trigger_held) begin
        st_o.phase_count = phase_inc;
        if (phase_inc < BrakeTicks) begin
          shoot            = BrakeDrive;
          st_o.pickup_hold = HalfDrive;
        end else if (phase_inc < cfg_i.back_off_ticks) begin
          st_o.pickup_hold = HalfDrive;
        end else begin
          shoot            = speed;
          st_o.pickup_hold = ({1'b0, phase_inc} < feed_limit) ? 16'd0 : cmd_i.stick_y;
        end
      end else begin
        // release braking ramp
        st_o.phase_count = phase_inc;
        if (phase_inc < ReleaseTicks) begin
          mag   = ramp_mag({1'b0, phase_inc[6:0]});
          shoot = 16'd0 - mag;
        end
        st_o.pickup_hold = cmd_i.stick_y;
      end
    end

    drv_o.shooter_drive = shoot;
    drv_o.pickup_drive  = st_o.pickup_hold;
  end

endmodule

// ----- hw/rtl/shooter_pickup_sequencer.sv -----
// top level of the shooter and pickup sequencer
//
//   channel   dir  handshake      payload
//   cmd_i     in   valid/ready    trigger, buttons, camera lock, stick y/z
//   drv_o     out  valid/ready    shooter_drive, pickup_drive (Q1.15)
//   cfg_*_i   in   write enable   register index, 16 bit write data
//
// the step logic sits between the state registers and the result register,
// so a new command is taken every cycle while drv_o is not stalled
// cmd ready is high whenever the result register is empty or being drained
// a stall on drv_o holds the result and blocks cmd_i, no state moves then
// rst_ni clears the result valid and resets the sequencer state and the config registers
`timescale 1ns / 1ps

module shooter_pickup_sequencer import sps_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i,
  sps_cmd_if.sink                 cmd_i,
  sps_drive_if.source             drv_o
);

  cfg_t   cfg_q;
  state_t st_q, st_d;
  drive_t drv_d, drv_q;
  logic   drv_valid_q;
  logic   cmd_take;

  // take a command when the result slot is free or emptying this cycle
  assign cmd_i.ready = !drv_valid_q || drv_o.ready;
  assign cmd_take    = cmd_i.valid && cmd_i.ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.back_off_ticks     <= BackOffReset;
      cfg_q.spin_up_ticks      <= SpinUpReset;
      cfg_q.min_shot_speed     <= MinSpeedReset;
      cfg_q.default_shot_speed <= DefSpeedReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BACK_OFF_TICKS:     cfg_q.back_off_ticks     <= cfg_data_i;
        CFG_SPIN_UP_TICKS:      cfg_q.spin_up_ticks      <= cfg_data_i;
        CFG_MIN_SHOT_SPEED:     cfg_q.min_shot_speed     <= cfg_data_i[14:0];
        CFG_DEFAULT_SHOT_SPEED: cfg_q.default_shot_speed <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // per-tick sequencing logic
  sps_step u_step (
    .cmd_i (cmd_i.data),
    .cfg_i (cfg_q),
    .st_i  (st_q),
    .st_o  (st_d),
    .drv_o (drv_d)
  );

  // sequencer state advances only on an accepted command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase_count  <= PhaseReset;
      st_q.hold_count   <= 8'd0;
      st_q.last_trigger <= 1'b0;
      st_q.pickup_hold  <= 16'd0;
    end else if (cmd_take) begin
      st_q <= st_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      drv_valid_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take) begin
      drv_q <= drv_d;
    end
  end

  assign drv_o.valid = drv_valid_q;
  assign drv_o.data  = drv_q;

  // buttons freeze the trigger phase counter
  a_button_freezes_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take && (cmd_i.data.reverse_held || cmd_i.data.advance_held)
      |=> $stable(st_q.phase_count) && $stable(st_q.last_trigger))
    else $error("phase counter moved while a shooter button was held");

  // a trigger edge restarts the phase counter
  a_edge_restarts_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take && !cmd_i.data.reverse_held && !cmd_i.data.advance_held &&
      (cmd_i.data.trigger_held != st_q.last_trigger)
      |=> st_q.phase_count == 16'd0)
    else $error("trigger edge did not restart the phase counter");

  // hold counter clears once both buttons are released
  a_hold_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take && !cmd_i.data.reverse_held && !cmd_i.data.advance_held
      |=> st_q.hold_count == 8'd0)
    else $error("hold counter not cleared");

  // every accepted command leaves a result behind
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take |=> drv_valid_q)
    else $error("accepted command produced no result");

  // pickup output follows the held pickup value
  a_pickup_tracks_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take |=> drv_q.pickup_drive == st_q.pickup_hold)
    else $error("pickup drive differs from held value");

endmodule
